@@ hw/rtl/msp_pkg.sv @@
`timescale 1ns / 1ps
package msp_pkg;

  localparam int NSERVO       = 24;
  localparam int IDX_W        = 5;
  localparam int PADDR_W      = 4;
  localparam int CALC_W       = 36;
  localparam int DEF_CHANNELS = 3;
  localparam int DEF_SLOTS    = 8;

  localparam logic [15:0] RST_POSITION = 16'd1000;
  localparam logic [15:0] RST_PERIOD   = 16'd20000;
  localparam logic [15:0] RST_SPD      = 16'd2816;

  typedef enum logic [3:0] {
    OP_TICK        = 4'd0,
    OP_SET         = 4'd1,
    OP_COMMAND     = 4'd2,
    OP_CALIBRATE   = 4'd3,
    OP_ENABLE      = 4'd4,
    OP_DISABLE     = 4'd5,
    OP_RECENTRE    = 4'd6,
    OP_ENABLE_ALL  = 4'd7,
    OP_DISABLE_ALL = 4'd8
  } op_t;

  typedef enum logic [1:0] {
    REG_SERVOS = 2'd0,
    REG_PERIOD = 2'd1,
    REG_SPD    = 2'd2,
    REG_SMOOTH = 2'd3
  } reg_t;

  typedef struct packed {
    logic [15:0] low;
    logic [15:0] high;
    logic [15:0] centre;
  } limits_t;

  localparam limits_t RST_LIMITS = '{low: 16'd0, high: 16'd20000, centre: 16'd1000};

endpackage

@@ hw/rtl/msp_ram.sv @@
`timescale 1ns / 1ps
module msp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 24,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/multiplexed_servo_pwm_controller.sv @@
`timescale 1ns / 1ps
// Multiplexed servo pulse generator.
// Commands enter on start with operation and its operand ports; a command word
// is taken at every clock edge where start is high and busy is low. busy is
// high only while rst is high, so one word can be taken every cycle.
// Each word produces exactly one result word, marked by done for one cycle:
// the edge that takes the word registers the command and issues the table
// reads, the next one updates the servo table and registers the result.
// Sustained rate is one word per cycle; the loop that sets it is the
// table update in the second stage, which feeds the next word directly.
// A tick word advances the PWM time base; the other operations edit the
// per-servo table (limits, centre, position, direction, enable).
// The result carries the pin levels, the addressed servo's position, an error
// flag and a period start flag. The receiver cannot stall: done is not held.
// Configuration goes through the APB port; write it only while no command is
// in flight. Reset returns every configuration register and the servo table to its
// default at once; table entries that were never written read as their defaults.
module multiplexed_servo_pwm_controller
  import msp_pkg::*;
#(
  parameter int CHANNELS          = DEF_CHANNELS,
  parameter int SLOTS_PER_CHANNEL = DEF_SLOTS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         operation,
  input  logic [IDX_W-1:0]   servo_index,
  input  logic [15:0]        position,
  input  logic [15:0]        limit_low,
  input  logic [15:0]        limit_high,
  input  logic               reverse_flag,
  input  logic signed [15:0] command_degrees,
  output logic               done,
  output logic [NSERVO-1:0]  pin_levels,
  output logic [15:0]        read_position,
  output logic               error,
  output logic               period_start,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int SLOT_W = (SLOTS_PER_CHANNEL > 1) ? $clog2(SLOTS_PER_CHANNEL) : 1;
  localparam int SPAN   = CHANNELS * SLOTS_PER_CHANNEL;
  localparam int SIDX_W = $clog2(SPAN + NSERVO);
  localparam int LIM_W  = $bits(limits_t);

  function automatic logic [15:0] clamp_pos(input logic [15:0] p, input limits_t lim);
    logic [15:0] r;
    r = p;
    if (r < lim.low) r = lim.low;
    if (r > lim.high) r = lim.high;
    return r;
  endfunction

  function automatic logic [SLOT_W-1:0] slot_after(input logic [SLOT_W-1:0] s);
    return (s == SLOT_W'(SLOTS_PER_CHANNEL - 1)) ? '0 : s + 1'b1;
  endfunction

  // ---------------------------------------------------------------- config
  logic [IDX_W-1:0] servos_in_use;
  logic [15:0]      period_ticks;
  logic [15:0]      steps_per_degree;
  logic [15:0]      smoothing_limit;
  logic             cfg_write;
  reg_t             cfg_reg;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign cfg_reg   = reg_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      servos_in_use    <= '0;
      period_ticks     <= RST_PERIOD;
      steps_per_degree <= RST_SPD;
      smoothing_limit  <= '0;
    end else if (cfg_write) begin
      unique case (cfg_reg)
        REG_SERVOS: servos_in_use <= (pwdata[IDX_W-1:0] > IDX_W'(NSERVO)) ?
                                     IDX_W'(NSERVO) : pwdata[IDX_W-1:0];
        REG_PERIOD: period_ticks     <= pwdata[15:0];
        REG_SPD:    steps_per_degree <= pwdata[15:0];
        REG_SMOOTH: smoothing_limit  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_reg)
      REG_SERVOS: prdata = {{(32-IDX_W){1'b0}}, servos_in_use};
      REG_PERIOD: prdata = {16'd0, period_ticks};
      REG_SPD:    prdata = {16'd0, steps_per_degree};
      REG_SMOOTH: prdata = {16'd0, smoothing_limit};
      default:    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------- input stage
  logic                accept;
  logic                item_valid;
  op_t                 item_op;
  logic [IDX_W-1:0]    item_idx;
  logic [15:0]         item_pos;
  logic [15:0]         item_lo;
  logic [15:0]         item_hi;
  logic                item_rev;
  logic signed [32:0]  item_dprod;
  logic [31:0]         item_lim;
  logic signed [32:0]  dprod;
  logic [31:0]         lim_prod;

  assign busy     = rst;
  assign accept   = start & ~busy;
  assign dprod    = command_degrees * $signed({1'b0, steps_per_degree});
  assign lim_prod = smoothing_limit * steps_per_degree;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_op    <= op_t'(operation);
      item_idx   <= servo_index;
      item_pos   <= position;
      item_lo    <= limit_low;
      item_hi    <= limit_high;
      item_rev   <= reverse_flag;
      item_dprod <= dprod;
      item_lim   <= lim_prod;
    end
  end

  // ---------------------------------------------------------- servo table
  logic [15:0]       tick_count;
  logic [15:0]       tick_count_next;
  logic [SLOT_W-1:0] active_slot;
  logic [SLOT_W-1:0] active_slot_next;
  logic [15:0]       channel_compare [CHANNELS];
  logic [NSERVO-1:0] en_bits, en_next;
  logic [NSERVO-1:0] rev_bits, rev_next;
  logic [NSERVO-1:0] pin_state, pin_next, pin_tick;
  logic [NSERVO-1:0] pos_valid, lim_valid, use_mask;

  // Last table write, forwarded to a word whose read was issued at the same edge.
  logic              pw_valid, lw_valid;
  logic [IDX_W-1:0]  pw_idx, lw_idx;
  logic [15:0]       pw_data;
  limits_t           lw_data;

  logic [IDX_W-1:0]  rd_idx;
  logic [SLOT_W-1:0] tick_raddr;
  logic [15:0]       pos_q;
  logic [LIM_W-1:0]  lim_q;
  logic [15:0]       tram_q [CHANNELS];

  logic              pos_we, lim_we;
  logic [15:0]       pos_wdata;
  limits_t           lim_wdata;

  assign rd_idx     = (servo_index < IDX_W'(NSERVO)) ? servo_index : '0;
  assign tick_raddr = slot_after(active_slot_next);

  msp_ram #(.WIDTH(16), .DEPTH(NSERVO)) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (item_idx),
    .wdata (pos_wdata),
    .raddr (rd_idx),
    .rdata (pos_q)
  );

  msp_ram #(.WIDTH(LIM_W), .DEPTH(NSERVO)) u_lim_ram (
    .clk   (clk),
    .we    (lim_we),
    .waddr (item_idx),
    .wdata (lim_wdata),
    .raddr (rd_idx),
    .rdata (lim_q)
  );

  // Each channel keeps its own copy of the positions of its slots, so a period
  // start can latch all channels at once.
  for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_chan
    localparam logic [SIDX_W-1:0] BASE = SIDX_W'(ch * SLOTS_PER_CHANNEL);
    logic [SIDX_W-1:0] woff;
    logic              we;

    assign woff = SIDX_W'(item_idx) - BASE;
    assign we   = pos_we && (SIDX_W'(item_idx) >= BASE) &&
                  (woff < SIDX_W'(SLOTS_PER_CHANNEL));

    msp_ram #(.WIDTH(16), .DEPTH(SLOTS_PER_CHANNEL)) u_tick_ram (
      .clk   (clk),
      .we    (we),
      .waddr (woff[SLOT_W-1:0]),
      .wdata (pos_wdata),
      .raddr (tick_raddr),
      .rdata (tram_q[ch])
    );
  end

  always_comb begin
    for (int i = 0; i < NSERVO; i++) begin
      use_mask[i] = IDX_W'(i) < servos_in_use;
    end
  end

  // ---------------------------------------------------- addressed servo
  logic             idx_in, in_range;
  logic [IDX_W-1:0] in_idx;
  logic [15:0]      cur_pos;
  limits_t          cur_lim;
  logic             cur_rev;

  assign idx_in   = item_idx < IDX_W'(NSERVO);
  assign in_range = item_idx < servos_in_use;
  assign in_idx   = idx_in ? item_idx : '0;
  assign cur_rev  = idx_in & rev_bits[in_idx];

  always_comb begin
    if (pw_valid && pw_idx == item_idx) begin
      cur_pos = pw_data;
    end else if (pos_valid[in_idx]) begin
      cur_pos = pos_q;
    end else begin
      cur_pos = RST_POSITION;
    end
    if (lw_valid && lw_idx == item_idx) begin
      cur_lim = lw_data;
    end else if (lim_valid[in_idx]) begin
      cur_lim = limits_t'(lim_q);
    end else begin
      cur_lim = RST_LIMITS;
    end
  end

  // Degree command, all in Q.16 step units.
  logic signed [16:0]       pos_diff;
  logic signed [CALC_W-1:0] d_raw, d_dir, old_off, lim_ext, bound_hi, bound_lo;
  logic signed [CALC_W-1:0] d_lim, target;
  logic [15:0]              cmd_steps, cmd_pos;

  always_comb begin
    d_raw    = {{(CALC_W-33){item_dprod[32]}}, item_dprod};
    d_dir    = cur_rev ? -d_raw : d_raw;
    pos_diff = $signed({1'b0, cur_pos}) - $signed({1'b0, cur_lim.centre});
    old_off  = {{(CALC_W-33){pos_diff[16]}}, pos_diff, 16'd0};
    lim_ext  = $signed({{(CALC_W-32){1'b0}}, item_lim});
    bound_hi = old_off + lim_ext;
    bound_lo = old_off - lim_ext;
    d_lim    = d_dir;
    if (smoothing_limit != '0) begin
      if (d_lim > bound_hi) d_lim = bound_hi;
      if (d_lim < bound_lo) d_lim = bound_lo;
    end
    target = $signed({{(CALC_W-32){1'b0}}, cur_lim.centre, 16'd0}) + d_lim;
    // Whole steps above the 16-bit range saturate before the limit clamp.
    if (|target[CALC_W-2:32]) begin
      cmd_steps = 16'hFFFF;
    end else begin
      cmd_steps = target[31:16];
    end
    if (target[CALC_W-1]) begin
      cmd_pos = cur_lim.low;
    end else begin
      cmd_pos = clamp_pos(cmd_steps, cur_lim);
    end
  end

  // ------------------------------------------------------------ time base
  logic                  tick, period_go;
  logic [SLOT_W-1:0]     slot_use;
  logic [SIDX_W-1:0]     sidx [CHANNELS];
  logic [CHANNELS-1:0]   ch_live;
  logic [15:0]           tick_pos [CHANNELS];
  logic [15:0]           cmp_new [CHANNELS];
  logic [15:0]           tick_inc;

  assign tick      = item_valid && (item_op == OP_TICK);
  assign period_go = tick && (tick_count == '0);
  assign slot_use  = period_go ? slot_after(active_slot) : active_slot;
  assign active_slot_next = tick ? slot_use : active_slot;
  assign tick_inc  = tick_count + 16'd1;
  assign tick_count_next = (tick_inc >= period_ticks) ? '0 : tick_inc;

  always_comb begin
    pin_tick = pin_state;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      sidx[ch]    = SIDX_W'(ch * SLOTS_PER_CHANNEL) + SIDX_W'(slot_use);
      ch_live[ch] = (sidx[ch] < SIDX_W'(NSERVO)) && en_bits[sidx[ch][IDX_W-1:0]];
      if (pw_valid && SIDX_W'(pw_idx) == sidx[ch]) begin
        tick_pos[ch] = pw_data;
      end else if (pos_valid[sidx[ch][IDX_W-1:0]]) begin
        tick_pos[ch] = tram_q[ch];
      end else begin
        tick_pos[ch] = RST_POSITION;
      end
      if (!period_go) begin
        cmp_new[ch] = channel_compare[ch];
      end else if (ch_live[ch]) begin
        cmp_new[ch] = tick_pos[ch];
      end else begin
        cmp_new[ch] = {1'b0, period_ticks[15:1]};
      end
      if (period_go && ch_live[ch]) begin
        pin_tick[sidx[ch][IDX_W-1:0]] = 1'b1;
      end
    end
    // The falling edge is checked after the rise, so a zero compare gives no pulse.
    for (int ch = 0; ch < CHANNELS; ch++) begin
      if (ch_live[ch] && cmp_new[ch] == tick_count) begin
        pin_tick[sidx[ch][IDX_W-1:0]] = 1'b0;
      end
    end
  end

  // ----------------------------------------------------------- operations
  logic err;

  always_comb begin
    pos_we    = 1'b0;
    pos_wdata = item_pos;
    lim_we    = 1'b0;
    lim_wdata = '{low: item_lo, high: item_hi, centre: item_pos};
    en_next   = en_bits;
    rev_next  = rev_bits;
    pin_next  = pin_state;
    err       = 1'b0;
    if (item_valid) begin
      unique case (item_op) inside
        OP_TICK: pin_next = pin_tick;
        OP_SET, OP_COMMAND, OP_CALIBRATE, OP_ENABLE, OP_DISABLE, OP_RECENTRE: begin
          if (!in_range) begin
            err = 1'b1;
          end else begin
            unique case (item_op)
              OP_SET: begin
                pos_we    = 1'b1;
                pos_wdata = clamp_pos(item_pos, cur_lim);
              end
              OP_COMMAND: begin
                pos_we    = 1'b1;
                pos_wdata = cmd_pos;
              end
              OP_CALIBRATE: begin
                if (item_hi <= item_lo || item_pos < item_lo || item_pos > item_hi) begin
                  err = 1'b1;
                end else begin
                  lim_we           = 1'b1;
                  pos_we           = 1'b1;
                  pos_wdata        = item_pos;
                  rev_next[in_idx] = item_rev;
                end
              end
              // Positions always sit inside their limits, so enabling needs
              // no reclamp.
              OP_ENABLE: en_next[in_idx] = 1'b1;
              OP_DISABLE: begin
                en_next[in_idx]  = 1'b0;
                pin_next[in_idx] = 1'b0;
              end
              OP_RECENTRE: begin
                pos_we    = 1'b1;
                pos_wdata = clamp_pos(cur_lim.centre, cur_lim);
              end
              default: ;
            endcase
          end
        end
        OP_ENABLE_ALL: en_next = en_bits | use_mask;
        OP_DISABLE_ALL: begin
          en_next  = en_bits & ~use_mask;
          pin_next = pin_state & ~(use_mask & en_bits);
        end
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------ registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count      <= '0;
      active_slot     <= '0;
      channel_compare <= '{default: '0};
      en_bits         <= '0;
      rev_bits        <= '0;
      pin_state       <= '0;
      pos_valid       <= '0;
      lim_valid       <= '0;
      pw_valid        <= 1'b0;
      lw_valid        <= 1'b0;
      done            <= 1'b0;
    end else begin
      en_bits   <= en_next;
      rev_bits  <= rev_next;
      pin_state <= pin_next;
      if (tick) begin
        tick_count      <= tick_count_next;
        active_slot     <= active_slot_next;
        channel_compare <= cmp_new;
      end
      if (pos_we) begin
        pos_valid[in_idx] <= 1'b1;
      end
      if (lim_we) begin
        lim_valid[in_idx] <= 1'b1;
      end
      pw_valid <= pos_we;
      lw_valid <= lim_we;
      done     <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    pw_idx  <= item_idx;
    pw_data <= pos_wdata;
    lw_idx  <= item_idx;
    lw_data <= lim_wdata;
    if (item_valid) begin
      pin_levels    <= pin_next;
      read_position <= idx_in ? (pos_we ? pos_wdata : cur_pos) : '0;
      error         <= err;
      period_start  <= period_go;
    end
  end

  // ----------------------------------------------------------- assertions
  a_result_follows : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("command word without a result two cycles later");

  a_pin_enabled : assert property (@(posedge clk) disable iff (rst)
    (pin_state & ~en_bits) == '0)
    else $error("pin high on a disabled servo");

  a_start_on_tick : assert property (@(posedge clk) disable iff (rst)
    (done && period_start) |-> $past(item_op == OP_TICK))
    else $error("period start flagged on a non-tick word");

endmodule

@@ dv/tb_multiplexed_servo_pwm_controller.sv @@
`timescale 1ns / 1ps
module tb_multiplexed_servo_pwm_controller;
  import msp_pkg::*;

  localparam int CHANNELS    = DEF_CHANNELS;
  localparam int SLOTS       = DEF_SLOTS;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [3:0]         op;
    logic [4:0]         idx;
    logic [15:0]        pos;
    logic [15:0]        lo;
    logic [15:0]        hi;
    logic               rev;
    logic signed [15:0] deg;
  } servo_cmd_t;

  typedef struct packed {
    logic [23:0] pins;
    logic [15:0] rpos;
    logic        err;
    logic        pstart;
  } servo_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [3:0]         operation = 4'd0;
  logic [IDX_W-1:0]   servo_index = '0;
  logic [15:0]        position = 16'd0;
  logic [15:0]        limit_low = 16'd0;
  logic [15:0]        limit_high = 16'd0;
  logic               reverse_flag = 1'b0;
  logic signed [15:0] command_degrees = 16'sd0;
  logic               done;
  logic [NSERVO-1:0]  pin_levels;
  logic [15:0]        read_position;
  logic               error;
  logic               period_start;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = 32'd0;
  logic [31:0]        prdata;
  logic               pready;

  multiplexed_servo_pwm_controller DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .servo_index(servo_index), .position(position),
    .limit_low(limit_low), .limit_high(limit_high), .reverse_flag(reverse_flag),
    .command_degrees(command_degrees), .done(done), .pin_levels(pin_levels),
    .read_position(read_position), .error(error), .period_start(period_start),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predicted controller state.
  int          m_in_use;
  logic [15:0] m_period, m_spd, m_smooth;
  logic [15:0] m_tick;
  int          m_slot;
  logic [15:0] m_cmp [CHANNELS];
  logic [15:0] m_lo [NSERVO];
  logic [15:0] m_hi [NSERVO];
  logic [15:0] m_ctr [NSERVO];
  logic [15:0] m_pos [NSERVO];
  logic [NSERVO-1:0] m_en, m_rev, m_pins;

  servo_cmd_t    cmd_words[$];
  servo_result_t due_results[$];
  servo_cmd_t    on_port;
  servo_result_t want_word, got_word;
  int words_queued = 0;
  int words_taken = 0;
  int idle_pct = 0;
  int mismatches = 0;
  int cycles = 0;

  function automatic logic [15:0] clamp_to_limits(int i, logic [15:0] p);
    logic [15:0] q;
    q = p;
    if (q < m_lo[i]) q = m_lo[i];
    if (q > m_hi[i]) q = m_hi[i];
    return q;
  endfunction

  function automatic void servo_on(int i);
    if (!m_en[i]) begin
      m_pos[i] = clamp_to_limits(i, m_pos[i]);
      m_en[i] = 1'b1;
    end
  endfunction

  function automatic void servo_off(int i);
    if (m_en[i]) begin
      m_en[i] = 1'b0;
      m_pins[i] = 1'b0;
    end
  endfunction

  function automatic servo_result_t apply_servo_word(servo_cmd_t c);
    servo_result_t r;
    int i, ch, idx;
    logic ok;
    longint d, old, lim, t;
    i = int'(c.idx);
    ok = (i < m_in_use);
    r.err = 1'b0;
    r.pstart = 1'b0;
    case (c.op)
      OP_TICK: begin
        if (m_tick == 16'd0) begin
          r.pstart = 1'b1;
          m_slot = (m_slot + 1) % SLOTS;
          for (ch = 0; ch < CHANNELS; ch++) begin
            idx = ch * SLOTS + m_slot;
            if (idx < NSERVO && m_en[idx]) begin
              m_pins[idx] = 1'b1;
              m_cmp[ch] = m_pos[idx];
            end else begin
              m_cmp[ch] = m_period / 16'd2;
            end
          end
        end
        for (ch = 0; ch < CHANNELS; ch++) begin
          idx = ch * SLOTS + m_slot;
          if (m_cmp[ch] == m_tick && idx < NSERVO && m_en[idx]) m_pins[idx] = 1'b0;
        end
        m_tick = m_tick + 16'd1;
        if (m_tick >= m_period) m_tick = 16'd0;
      end
      OP_SET, OP_COMMAND, OP_CALIBRATE, OP_ENABLE, OP_DISABLE, OP_RECENTRE: begin
        if (!ok) begin
          r.err = 1'b1;
        end else begin
          case (c.op)
            OP_SET: m_pos[i] = clamp_to_limits(i, c.pos);
            OP_COMMAND: begin
              // Offsets are Q16.16 timer steps; smoothing bounds the change from
              // the current offset rather than the new angle.
              d = longint'($signed(c.deg)) * longint'(m_spd);
              if (m_rev[i]) d = -d;
              if (m_smooth != 16'd0) begin
                old = (longint'(m_pos[i]) - longint'(m_ctr[i])) * 65536;
                lim = longint'(m_smooth) * longint'(m_spd);
                if (d > old + lim) d = old + lim;
                if (d < old - lim) d = old - lim;
              end
              t = longint'(m_ctr[i]) * 65536 + d;
              if (t < 0) begin
                m_pos[i] = m_lo[i];
              end else begin
                t = t >>> 16;
                if (t > 65535) t = 65535;
                m_pos[i] = clamp_to_limits(i, t[15:0]);
              end
            end
            OP_CALIBRATE: begin
              if (c.hi <= c.lo || c.pos < c.lo || c.pos > c.hi) begin
                r.err = 1'b1;
              end else begin
                m_lo[i] = c.lo;
                m_hi[i] = c.hi;
                m_ctr[i] = c.pos;
                m_pos[i] = c.pos;
                m_rev[i] = c.rev;
              end
            end
            OP_ENABLE: servo_on(i);
            OP_DISABLE: servo_off(i);
            default: m_pos[i] = clamp_to_limits(i, m_ctr[i]);
          endcase
        end
      end
      OP_ENABLE_ALL: for (idx = 0; idx < m_in_use; idx++) servo_on(idx);
      OP_DISABLE_ALL: for (idx = 0; idx < m_in_use; idx++) servo_off(idx);
      default: ;
    endcase
    r.pins = m_pins;
    r.rpos = (i < NSERVO) ? m_pos[i] : 16'd0;
    return r;
  endfunction

  // Driver: a word is taken when start is high and busy is low at the edge.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        due_results.push_back(apply_servo_word(on_port));
        words_taken++;
      end
      if (!(start && busy)) begin
        if (cmd_words.size() != 0 && $urandom_range(99) >= idle_pct) begin
          on_port = cmd_words.pop_front();
          start <= 1'b1;
          operation <= on_port.op;
          servo_index <= on_port.idx;
          position <= on_port.pos;
          limit_low <= on_port.lo;
          limit_high <= on_port.hi;
          reverse_flag <= on_port.rev;
          command_degrees <= on_port.deg;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every done cycle carries exactly one result word.
  always @(posedge clk) begin
    if (!rst && done) begin
      got_word.pins = pin_levels;
      got_word.rpos = read_position;
      got_word.err = error;
      got_word.pstart = period_start;
      if (due_results.size() == 0) begin
        if (mismatches < 10)
          $display("Unexpected result word: pins %h pos %0d err %b start %b",
                   got_word.pins, got_word.rpos, got_word.err, got_word.pstart);
        mismatches++;
      end else begin
        want_word = due_results.pop_front();
        if (got_word.pins !== want_word.pins || got_word.rpos !== want_word.rpos ||
            got_word.err !== want_word.err || got_word.pstart !== want_word.pstart) begin
          if (mismatches < 10)
            $display("Mismatch: expected pins %h pos %0d err %b start %b, got pins %h pos %0d err %b start %b",
                     want_word.pins, want_word.rpos, want_word.err, want_word.pstart,
                     got_word.pins, got_word.rpos, got_word.err, got_word.pstart);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(reg_t r, logic [31:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (r)
      REG_SERVOS: m_in_use = (int'(v[4:0]) > NSERVO) ? NSERVO : int'(v[4:0]);
      REG_PERIOD: m_period = v[15:0];
      REG_SPD: m_spd = v[15:0];
      default: m_smooth = v[15:0];
    endcase
  endtask

  task automatic set_config(int servos, int period, int spd, int smooth);
    write_reg(REG_SERVOS, servos);
    write_reg(REG_PERIOD, period);
    write_reg(REG_SPD, spd);
    write_reg(REG_SMOOTH, smooth);
  endtask

  task automatic queue_word(op_t op, int idx, int pos, int lo, int hi, bit rev, int deg);
    servo_cmd_t c;
    c.op = op;
    c.idx = 5'(idx);
    c.pos = 16'(pos);
    c.lo = 16'(lo);
    c.hi = 16'(hi);
    c.rev = rev;
    c.deg = 16'(deg);
    cmd_words.push_back(c);
    words_queued++;
  endtask

  // Mostly ticks and well-formed edits on registered servos, with some noise.
  task automatic queue_random(int n);
    servo_cmd_t c;
    int k, r, span, lo_i, hi_i;
    for (k = 0; k < n; k++) begin
      c.op = OP_TICK;
      c.idx = 5'($urandom_range(31));
      c.pos = 16'($urandom);
      c.lo = 16'($urandom);
      c.hi = 16'($urandom);
      c.rev = 1'($urandom);
      c.deg = 16'($urandom);
      span = int'(m_period) + 4;
      if (span > 65535) span = 65535;
      if (m_in_use != 0 && $urandom_range(9) != 0) c.idx = 5'($urandom_range(m_in_use - 1));
      r = $urandom_range(999);
      if (r < 520) begin
        c.op = OP_TICK;
      end else if (r < 620) begin
        c.op = OP_SET;
        if ($urandom_range(3) != 0) c.pos = 16'($urandom_range(span));
      end else if (r < 740) begin
        c.op = OP_COMMAND;
        if ($urandom_range(1) != 0) c.deg = 16'($urandom_range(4096) - 2048);
      end else if (r < 810) begin
        c.op = OP_CALIBRATE;
        if ($urandom_range(4) != 0) begin
          lo_i = $urandom_range(span - 1);
          hi_i = lo_i + 1 + $urandom_range(span);
          if (hi_i > 65535) hi_i = 65535;
          c.lo = 16'(lo_i);
          c.hi = 16'(hi_i);
          c.pos = 16'($urandom_range(hi_i, lo_i));
        end
      end else if (r < 870) begin
        c.op = OP_ENABLE;
      end else if (r < 910) begin
        c.op = OP_DISABLE;
      end else if (r < 950) begin
        c.op = OP_RECENTRE;
      end else if (r < 970) begin
        c.op = OP_ENABLE_ALL;
      end else if (r < 985) begin
        c.op = OP_DISABLE_ALL;
      end else begin
        c.op = 4'($urandom_range(15, int'(OP_DISABLE_ALL) + 1));
      end
      cmd_words.push_back(c);
      words_queued++;
    end
  endtask

  task automatic run_words(int pct);
    idle_pct = pct;
    while (words_taken != words_queued || due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    m_in_use = 0;
    m_period = RST_PERIOD;
    m_spd = RST_SPD;
    m_smooth = 16'd0;
    m_tick = 16'd0;
    m_slot = 0;
    for (int ch = 0; ch < CHANNELS; ch++) m_cmp[ch] = 16'd0;
    for (int i = 0; i < NSERVO; i++) begin
      m_lo[i] = RST_LIMITS.low;
      m_hi[i] = RST_LIMITS.high;
      m_ctr[i] = RST_LIMITS.centre;
      m_pos[i] = RST_POSITION;
    end
    m_en = '0;
    m_rev = '0;
    m_pins = '0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Out of reset no servo is registered.
    queue_word(OP_SET, 0, 500, 0, 0, 0, 0);
    queue_word(OP_TICK, 0, 0, 0, 0, 0, 0);
    run_words(38);

    set_config(NSERVO, 2, 256, 0);
    queue_word(OP_CALIBRATE, 0, 50, 10, 100, 0, 0);
    queue_word(OP_CALIBRATE, 1, 65535, 0, 65535, 1, 0);
    queue_word(OP_CALIBRATE, 2, 5, 5, 5, 0, 0);
    queue_word(OP_CALIBRATE, 2, 9, 10, 20, 0, 0);
    queue_word(OP_CALIBRATE, 2, 21, 10, 20, 0, 0);
    queue_word(OP_SET, 0, 0, 0, 0, 0, 0);
    queue_word(OP_SET, 0, 65535, 0, 0, 0, 0);
    queue_word(OP_COMMAND, 0, 0, 0, 0, 0, 32767);
    queue_word(OP_COMMAND, 0, 0, 0, 0, 0, -32768);
    queue_word(OP_COMMAND, 1, 0, 0, 0, 0, -32768);
    queue_word(OP_SET, 9, 1, 0, 0, 0, 0);
    queue_word(OP_ENABLE, 9, 0, 0, 0, 0, 0);
    queue_word(OP_ENABLE, 1, 0, 0, 0, 0, 0);
    repeat (6) queue_word(OP_TICK, 0, 0, 0, 0, 0, 0);
    queue_word(OP_DISABLE, 1, 0, 0, 0, 0, 0);
    queue_word(OP_RECENTRE, 0, 0, 0, 0, 0, 0);
    queue_word(OP_SET, 24, 100, 0, 0, 0, 0);
    queue_word(OP_ENABLE, 31, 0, 0, 0, 0, 0);
    queue_word(OP_ENABLE_ALL, 0, 0, 0, 0, 0, 0);
    queue_word(OP_DISABLE_ALL, 0, 0, 0, 0, 0, 0);
    run_words(38);

    // With smoothing on, a full-scale command moves 256 degrees, one timer step, at most.
    write_reg(REG_SMOOTH, 256);
    queue_word(OP_COMMAND, 0, 0, 0, 0, 0, 32767);
    queue_word(OP_COMMAND, 0, 0, 0, 0, 0, -32768);
    run_words(38);

    set_config(NSERVO, 40, 2816, 0);
    queue_random(500);
    run_words(38);

    set_config(12, 2, 65535, 65535);
    queue_random(400);
    run_words(82);

    set_config(NSERVO, 300, 0, 1);
    queue_random(500);
    run_words(0);

    set_config(31, 17, 100, 512);
    queue_random(300);
    run_words(0);

    set_config(5, 65535, 384, 0);
    queue_random(150);
    run_words(0);

    set_config(0, 20000, 2816, 0);
    queue_random(100);
    run_words(0);

    repeat (6) @(posedge clk);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
